@@ rtl/drsc_pkg.sv @@
// Package for the dirty rectangle set coalescer.
// Holds the rectangle type, the controller states, the datapath command and status structs and the box helpers.
package drsc_pkg;

  localparam int SetCapacityDef = 16;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [16:0]        w;
    logic [16:0]        h;
  } box_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FOLD,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan_step;
    logic merge_hit;
    logic append;
    logic fold_start;
    logic fold_step;
    logic fold_end;
    logic sum_start;
    logic sum_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic empty;
    logic hit;
    logic scan_last;
    logic full;
    logic fold_last;
    logic sum_last;
  } stat_t;

  function automatic logic signed [17:0] right_edge(box_t b);
    right_edge = 18'(b.x) + 18'(signed'({1'b0, b.w}));
  endfunction

  function automatic logic signed [17:0] bottom_edge(box_t b);
    bottom_edge = 18'(b.y) + 18'(signed'({1'b0, b.h}));
  endfunction

  function automatic box_t box_union(box_t a, box_t b);
    logic signed [17:0] ra;
    logic signed [17:0] rb;
    logic signed [17:0] ba;
    logic signed [17:0] bb;
    logic signed [17:0] rt;
    logic signed [17:0] bt;
    box_t r;
    ra = right_edge(a);
    rb = right_edge(b);
    ba = bottom_edge(a);
    bb = bottom_edge(b);
    rt = (ra > rb) ? ra : rb;
    bt = (ba > bb) ? ba : bb;
    r.x = (a.x < b.x) ? a.x : b.x;
    r.y = (a.y < b.y) ? a.y : b.y;
    r.w = 17'(rt - 18'(r.x));
    r.h = 17'(bt - 18'(r.y));
    box_union = r;
  endfunction

endpackage

@@ rtl/drsc_ctrl.sv @@
// Controller state machine of the dirty rectangle set coalescer.
// Depends on drsc_pkg for states, commands and status.
module drsc_ctrl import drsc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   ov_r;
  logic   ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.mode) begin
          cmd.clear     = 1'b1;
          cmd.sum_start = 1'b1;
          state_nxt     = ST_SUM;
        end else if (stat.empty) begin
          cmd.sum_start = 1'b1;
          state_nxt     = ST_SUM;
        end else if (stat.hit) begin
          cmd.merge_hit = 1'b1;
          cmd.sum_start = 1'b1;
          state_nxt     = ST_SUM;
        end else if (!stat.scan_last) begin
          cmd.scan_step = 1'b1;
        end else if (!stat.full) begin
          cmd.append    = 1'b1;
          cmd.sum_start = 1'b1;
          state_nxt     = ST_SUM;
        end else begin
          cmd.fold_start = 1'b1;
          state_nxt      = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (stat.fold_last) begin
          cmd.fold_end  = 1'b1;
          cmd.sum_start = 1'b1;
          state_nxt     = ST_SUM;
        end else begin
          cmd.fold_step = 1'b1;
        end
      end
      ST_SUM: begin
        if (stat.sum_last) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(ov_r && out_stall) || !cmd.out_load)
        else $error("Result word overwritten while stalled.");
    end
  end

  property p_load_idle;
    @(posedge clk) disable iff (!rst_n) cmd.load |-> $past(1'b1) && state_r == ST_IDLE;
  endproperty
  a_load_idle: assert property (p_load_idle) else $error("Load outside idle.");

  property p_after_load;
    @(posedge clk) disable iff (!rst_n) cmd.load |=> state_r == ST_SCAN;
  endproperty
  a_after_load: assert property (p_after_load) else $error("Load did not start a scan.");

  property p_out;
    @(posedge clk) disable iff (!rst_n) cmd.out_load |=> out_valid;
  endproperty
  a_out: assert property (p_out) else $error("Result word not presented.");

endmodule

@@ rtl/drsc_dp.sv @@
// Datapath of the dirty rectangle set coalescer: entry store, scan, fold and bounds.
// Depends on drsc_pkg; steered by drsc_ctrl through cmd_t.
module drsc_dp import drsc_pkg::*; #(
  parameter int SET_CAPACITY = SetCapacityDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               in_mode,
  input  logic signed [15:0] in_rect_x,
  input  logic signed [15:0] in_rect_y,
  input  logic signed [15:0] in_rect_width,
  input  logic signed [15:0] in_rect_height,
  output logic               out_accepted,
  output logic [4:0]         out_entry_count,
  output logic signed [15:0] out_bounds_x,
  output logic signed [15:0] out_bounds_y,
  output logic [16:0]        out_bounds_width,
  output logic [16:0]        out_bounds_height
);

  localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CW = $clog2(SET_CAPACITY + 1);

  box_t           mem_r [SET_CAPACITY];
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  idx_r;
  box_t           rect_r;
  logic           mode_r;
  logic           empty_r;
  logic           acc_r;
  box_t           accum_r;
  box_t           entry;
  logic           any_r;
  logic signed [17:0] er, eb, rr, rb, lx, ly, rx, ry;
  logic           touch;

  assign entry = mem_r[idx_r[IW-1:0]];

  always_comb begin
    er = right_edge(entry);
    eb = bottom_edge(entry);
    rr = right_edge(rect_r);
    rb = bottom_edge(rect_r);
    lx = (entry.x > rect_r.x) ? 18'(entry.x) : 18'(rect_r.x);
    ly = (entry.y > rect_r.y) ? 18'(entry.y) : 18'(rect_r.y);
    rx = (er < rr) ? er : rr;
    ry = (eb < rb) ? eb : rb;
    touch = ((lx < rx) && (ly < ry)) || er == 18'(rect_r.x) || rr == 18'(entry.x) ||
            eb == 18'(rect_r.y) || rb == 18'(entry.y);
  end

  assign stat.mode      = mode_r;
  assign stat.empty     = empty_r;
  assign stat.hit       = (idx_r < count_r) && touch;
  assign stat.scan_last = (idx_r + CW'(1) >= count_r);
  assign stat.full      = (count_r == CW'(SET_CAPACITY));
  assign stat.fold_last = (idx_r == CW'(SET_CAPACITY - 1));
  assign stat.sum_last  = (idx_r >= count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.fold_end) begin
      count_r <= CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      rect_r.x <= in_rect_x;
      rect_r.y <= in_rect_y;
      rect_r.w <= 17'(unsigned'(in_rect_width));
      rect_r.h <= 17'(unsigned'(in_rect_height));
      empty_r  <= (in_rect_width <= 0) || (in_rect_height <= 0);
      idx_r    <= '0;
      acc_r    <= 1'b0;
    end
    if (cmd.scan_step || cmd.fold_step || cmd.sum_step) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.merge_hit) begin
      mem_r[idx_r[IW-1:0]] <= box_union(entry, rect_r);
      acc_r                <= 1'b1;
    end
    if (cmd.append) begin
      mem_r[count_r[IW-1:0]] <= rect_r;
      acc_r                  <= 1'b1;
    end
    if (cmd.fold_start) begin
      accum_r <= rect_r;
      idx_r   <= '0;
    end
    if (cmd.fold_step) begin
      accum_r <= box_union(accum_r, entry);
    end
    if (cmd.fold_end) begin
      mem_r[0] <= box_union(accum_r, entry);
      acc_r    <= 1'b1;
    end
    if (cmd.sum_start) begin
      idx_r <= '0;
      any_r <= 1'b0;
    end
    if (cmd.sum_step) begin
      accum_r <= any_r ? box_union(accum_r, entry) : entry;
      any_r   <= 1'b1;
    end
    if (cmd.out_load) begin
      out_accepted      <= acc_r;
      out_entry_count   <= 5'(count_r);
      out_bounds_x      <= any_r ? accum_r.x : '0;
      out_bounds_y      <= any_r ? accum_r.y : '0;
      out_bounds_width  <= any_r ? accum_r.w : '0;
      out_bounds_height <= any_r ? accum_r.h : '0;
    end
  end

  property p_count_max;
    @(posedge clk) disable iff (!rst_n) count_r <= CW'(SET_CAPACITY);
  endproperty
  a_count_max: assert property (p_count_max) else $error("Entry count over capacity.");

  property p_fold_count;
    @(posedge clk) disable iff (!rst_n) cmd.fold_end |=> count_r == CW'(1);
  endproperty
  a_fold_count: assert property (p_fold_count) else $error("Fold left wrong count.");

  property p_append_grow;
    @(posedge clk) disable iff (!rst_n) cmd.append |=> count_r == $past(count_r) + CW'(1);
  endproperty
  a_append_grow: assert property (p_append_grow) else $error("Append did not grow count.");

endmodule

@@ rtl/dirty_rect_set_coalescer.sv @@
// Top level of the dirty rectangle set coalescer.
// Joins drsc_ctrl and drsc_dp; depends on drsc_pkg.
//
// Input channel: in_valid/in_stall carry one word (mode and rectangle).
// Mode 1 clears the set; mode 0 adds a non-empty rectangle to the set.
// Output channel: out_valid/out_stall carry one result word per input word:
// acceptance, entry count and bounding box of all entries.
// An item is loaded, then scanned against the stored entries up to the
// first touching one; when the set is full and no entry touches, all entries
// and the rectangle are folded into one entry. Then the bounding box is
// summed over the held entries and the result is registered.
// The scan, the fold and the sum share one entry read port.
// One item is in work at a time; in_stall is high while it is.
// A result word waits in the output register while the receiver stalls;
// the block holds the next result until that word is taken.
// Reset empties the set and clears out_valid; no clearing pass is needed.
module dirty_rect_set_coalescer import drsc_pkg::*; #(
  parameter int SET_CAPACITY = SetCapacityDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [15:0] in_rect_x,
  input  logic signed [15:0] in_rect_y,
  input  logic signed [15:0] in_rect_width,
  input  logic signed [15:0] in_rect_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [4:0]         out_entry_count,
  output logic signed [15:0] out_bounds_x,
  output logic signed [15:0] out_bounds_y,
  output logic [16:0]        out_bounds_width,
  output logic [16:0]        out_bounds_height
);

  cmd_t  cmd;
  stat_t stat;

  drsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  drsc_dp #(.SET_CAPACITY(SET_CAPACITY)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_rect_x        (in_rect_x),
    .in_rect_y        (in_rect_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .out_accepted     (out_accepted),
    .out_entry_count  (out_entry_count),
    .out_bounds_x     (out_bounds_x),
    .out_bounds_y     (out_bounds_y),
    .out_bounds_width (out_bounds_width),
    .out_bounds_height(out_bounds_height)
  );

endmodule
